// ===== design/cyclic_relay_countdown_timer_unit_assert.svh =====
// Assertion macros shared by the relay countdown timer RTL.
`ifndef CYCLIC_RELAY_COUNTDOWN_TIMER_UNIT_ASSERT_SVH
`define CYCLIC_RELAY_COUNTDOWN_TIMER_UNIT_ASSERT_SVH

// Check a property on i_clk, ignored while reset is asserted.
`define CRCT_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check a property on i_clk, including cycles under reset.
`define CRCT_ASSERT_RST(lbl, prop, msg) \
    lbl: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

// ===== design/crct_pkg.sv =====
// Types, constants and helpers of the relay countdown timer.
`default_nettype none
package crct_pkg;

    localparam int unsigned CfgW       = 8;
    localparam int unsigned CfgIdxW    = 3;
    localparam int unsigned TicksW     = 14;
    localparam int unsigned ElapsedW   = 20;
    localparam int unsigned HoursW     = 8;
    localparam int unsigned MinSecW    = 6;
    localparam int unsigned FragW      = 8;
    localparam int unsigned SettleSteps = 3;

    localparam logic [MinSecW-1:0]  LAST_MIN    = 6'd59;
    localparam logic [ElapsedW-1:0] ELAPSED_MAX = 20'hFFFFF;

    typedef enum logic [CfgIdxW-1:0] {
        CFG_FIRST_ON_MINUTES = 3'd0,
        CFG_ON_MINUTES       = 3'd1,
        CFG_OFF_MINUTES      = 3'd2,
        CFG_TOTAL_HOURS      = 3'd3,
        CFG_REFILL_AMOUNT    = 3'd4,
        CFG_START_FRAGRANCE  = 3'd5
    } t_cfg_idx;

    typedef enum logic [3:0] {
        PH_FIRST_ON = 4'b0001,
        PH_OFF      = 4'b0010,
        PH_ON       = 4'b0100,
        PH_DONE     = 4'b1000
    } t_phase;

    typedef struct packed {
        logic [CfgW-1:0] first_on_minutes;
        logic [CfgW-1:0] on_minutes;
        logic [CfgW-1:0] off_minutes;
        logic [CfgW-1:0] total_hours;
        logic [CfgW-1:0] refill_amount;
        logic [CfgW-1:0] start_fragrance;
    } t_cfg;

    typedef struct packed {
        t_phase              phase;
        logic [TicksW-1:0]   ticks_left;
        logic [ElapsedW-1:0] elapsed;
        logic [HoursW-1:0]   hours;
        logic [MinSecW-1:0]  minutes;
        logic [MinSecW-1:0]  seconds;
        logic [FragW-1:0]    fragrance;
    } t_state;

    typedef struct packed {
        logic restart;
        logic refill_pressed;
    } t_tick;

    // m * 60 as 64m - 4m
    function automatic logic [TicksW-1:0] mins_to_ticks(input logic [CfgW-1:0] m);
        logic [TicksW-1:0] w;
        begin
            w = TicksW'(m);
            return (w << 6) - (w << 2);
        end
    endfunction

    // h * 3600 as 2048h + 1024h + 512h + 16h
    function automatic logic [ElapsedW-1:0] hours_to_secs(input logic [CfgW-1:0] h);
        logic [ElapsedW-1:0] w;
        begin
            w = ElapsedW'(h);
            return (w << 11) + (w << 10) + (w << 9) + (w << 4);
        end
    endfunction

endpackage
`default_nettype wire

// ===== design/crct_if.sv =====
// Handshake channel interfaces: tick items, result items, register writes.
`default_nettype none
interface crct_in_if;
    logic valid;
    logic ready;
    logic restart;
    logic refill_pressed;
    modport source (output valid, output restart, output refill_pressed, input ready);
    modport sink   (input valid, input restart, input refill_pressed, output ready);
endinterface

interface crct_out_if;
    logic                              valid;
    logic                              ready;
    logic                              relay_on;
    logic [crct_pkg::HoursW-1:0]       hours_left;
    logic [crct_pkg::MinSecW-1:0]      minutes_left;
    logic [crct_pkg::MinSecW-1:0]      seconds_left;
    logic [crct_pkg::FragW-1:0]        fragrance_left;
    logic                              fragrance_over;
    logic                              run_done;
    modport source (output valid, output relay_on, output hours_left, output minutes_left,
                    output seconds_left, output fragrance_left, output fragrance_over,
                    output run_done, input ready);
    modport sink   (input valid, input relay_on, input hours_left, input minutes_left,
                    input seconds_left, input fragrance_left, input fragrance_over,
                    input run_done, output ready);
endinterface

interface crct_cfg_if;
    logic                           valid;
    logic                           ready;
    logic [crct_pkg::CfgIdxW-1:0]   index;
    logic [crct_pkg::CfgW-1:0]      data;
    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

// ===== design/crct_cfg.sv =====
// Configuration register file of the relay countdown timer.
`default_nettype none
module crct_cfg (
    input  wire logic           i_clk,
    input  wire logic           i_rst_n,
    crct_cfg_if.sink            i_cfg,
    output crct_pkg::t_cfg      o_cfg
);
    crct_pkg::t_cfg r_cfg;
    crct_pkg::t_cfg n_cfg;

    assign i_cfg.ready = 1'b1;
    assign o_cfg       = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg.valid) begin
            unique case (i_cfg.index)
                crct_pkg::CFG_FIRST_ON_MINUTES: n_cfg.first_on_minutes = i_cfg.data;
                crct_pkg::CFG_ON_MINUTES:       n_cfg.on_minutes       = i_cfg.data;
                crct_pkg::CFG_OFF_MINUTES:      n_cfg.off_minutes      = i_cfg.data;
                crct_pkg::CFG_TOTAL_HOURS:      n_cfg.total_hours      = i_cfg.data;
                crct_pkg::CFG_REFILL_AMOUNT:    n_cfg.refill_amount    = i_cfg.data;
                crct_pkg::CFG_START_FRAGRANCE:  n_cfg.start_fragrance  = i_cfg.data;
                default:                        n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else begin
            r_cfg <= n_cfg;
        end
    end
endmodule
`default_nettype wire

// ===== design/crct_step.sv =====
// Next-state logic for one one-second tick: phase boundaries, countdown, fragrance.
`default_nettype none
module crct_step (
    input  wire crct_pkg::t_cfg    i_cfg,
    input  wire crct_pkg::t_state  i_state,
    input  wire crct_pkg::t_tick   i_tick,
    output crct_pkg::t_state       o_state,
    output logic                   o_relay_on
);
    crct_pkg::t_state s0;
    crct_pkg::t_state s;
    logic             limit_hit;

    always_comb begin
        // restart reloads the run before the tick is handled
        s0 = i_state;
        if (i_tick.restart) begin
            s0.phase      = crct_pkg::PH_FIRST_ON;
            s0.ticks_left = crct_pkg::mins_to_ticks(i_cfg.first_on_minutes);
            s0.elapsed    = '0;
            s0.hours      = i_cfg.total_hours;
            s0.minutes    = '0;
            s0.seconds    = '0;
            s0.fragrance  = i_cfg.start_fragrance;
        end
        limit_hit = s0.elapsed >= crct_pkg::hours_to_secs(i_cfg.total_hours);

        // walk over zero-length phases, at most three boundaries
        s = s0;
        for (int n = 0; n < crct_pkg::SettleSteps; n++) begin
            if (s.phase != crct_pkg::PH_DONE && s.ticks_left == '0) begin
                if (limit_hit) begin
                    s.phase = crct_pkg::PH_DONE;
                end else if (s.phase == crct_pkg::PH_OFF) begin
                    s.phase      = crct_pkg::PH_ON;
                    s.ticks_left = crct_pkg::mins_to_ticks(i_cfg.on_minutes);
                end else begin
                    s.phase      = crct_pkg::PH_OFF;
                    s.ticks_left = crct_pkg::mins_to_ticks(i_cfg.off_minutes);
                end
            end
        end
        // on and off both zero never reach a nonzero phase
        if (s.phase != crct_pkg::PH_DONE && s.ticks_left == '0) begin
            s.phase = crct_pkg::PH_DONE;
        end

        o_relay_on = 1'b0;
        if (s.phase != crct_pkg::PH_DONE) begin
            o_relay_on = s.phase != crct_pkg::PH_OFF;
            if (i_tick.refill_pressed) begin
                s.fragrance = i_cfg.refill_amount;
            end
            // countdown holds at 0:00:00
            if (s.seconds == '0) begin
                if (s.minutes != '0 || s.hours != '0) begin
                    if (s.minutes == '0) begin
                        s.minutes = crct_pkg::LAST_MIN;
                        s.hours   = s.hours - crct_pkg::HoursW'(1);
                        if (s.fragrance != '0) begin
                            s.fragrance = s.fragrance - crct_pkg::FragW'(1);
                        end
                    end else begin
                        s.minutes = s.minutes - crct_pkg::MinSecW'(1);
                    end
                    s.seconds = crct_pkg::LAST_MIN;
                end
            end else begin
                s.seconds = s.seconds - crct_pkg::MinSecW'(1);
            end
            if (s.elapsed != crct_pkg::ELAPSED_MAX) begin
                s.elapsed = s.elapsed + crct_pkg::ElapsedW'(1);
            end
            s.ticks_left = s.ticks_left - crct_pkg::TicksW'(1);
        end
        o_state = s;
    end
endmodule
`default_nettype wire

// ===== design/cyclic_relay_countdown_timer_unit.sv =====
// Relay countdown timer: one tick item in, one status item out per tick.
//
// i_item carries one item per one-second tick: restart (reload the run from the
// initial on phase, then handle this tick) and refill_pressed (reload the
// fragrance counter). o_result returns one item per tick: relay level during
// the tick, the hh:mm:ss countdown, fragrance count and alarm, and run_done.
// i_cfg writes the six 8-bit registers by index; ready is always high. Writes
// take effect at the next restart, refill or phase boundary that uses them.
// A tick is loaded into the input register when it is accepted; the result
// register loads from it once the result side holds no untaken result.
// Throughput: one tick per cycle while the receiver does not stall, set by the
// combinational next-state logic between the input, state and result registers.
// Reset clears the valid flags, state and configuration (payload registers are
// not reset) and puts the run in the initial on phase with the countdown at
// 0:00:00. When the receiver stalls, the result register holds; the input
// register still takes one more tick, then ready drops until the result is taken.
`default_nettype none
`include "cyclic_relay_countdown_timer_unit_assert.svh"
module cyclic_relay_countdown_timer_unit (
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    crct_in_if.sink     i_item,
    crct_cfg_if.sink    i_cfg,
    crct_out_if.source  o_result
);
    crct_pkg::t_cfg   w_cfg;
    crct_pkg::t_state r_st;
    crct_pkg::t_state w_next;
    crct_pkg::t_tick  r_s1;
    logic             r_s1_valid;
    logic             r_out_valid;
    logic             w_relay;
    logic             w_out_free;
    logic             w_s1_fire;
    logic             w_in_fire;

    logic                            r_relay_on;
    logic [crct_pkg::HoursW-1:0]     r_hours;
    logic [crct_pkg::MinSecW-1:0]    r_minutes;
    logic [crct_pkg::MinSecW-1:0]    r_seconds;
    logic [crct_pkg::FragW-1:0]      r_fragrance;
    logic                            r_done;

    crct_cfg u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .o_cfg   (w_cfg)
    );

    crct_step u_step (
        .i_cfg      (w_cfg),
        .i_state    (r_st),
        .i_tick     (r_s1),
        .o_state    (w_next),
        .o_relay_on (w_relay)
    );

    assign w_out_free   = !r_out_valid || o_result.ready;
    assign w_s1_fire    = r_s1_valid && w_out_free;
    assign i_item.ready = !r_s1_valid || w_out_free;
    assign w_in_fire    = i_item.valid && i_item.ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_st.phase      <= crct_pkg::PH_FIRST_ON;
            r_st.ticks_left <= '0;
            r_st.elapsed    <= '0;
            r_st.hours      <= '0;
            r_st.minutes    <= '0;
            r_st.seconds    <= '0;
            r_st.fragrance  <= '0;
        end else begin
            if (i_item.ready) begin
                r_s1_valid <= i_item.valid;
            end
            if (w_s1_fire) begin
                r_st        <= w_next;
                r_out_valid <= 1'b1;
            end else if (o_result.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_s1.restart        <= i_item.restart;
            r_s1.refill_pressed <= i_item.refill_pressed;
        end
        if (w_s1_fire) begin
            r_relay_on  <= w_relay;
            r_hours     <= w_next.hours;
            r_minutes   <= w_next.minutes;
            r_seconds   <= w_next.seconds;
            r_fragrance <= w_next.fragrance;
            r_done      <= w_next.phase == crct_pkg::PH_DONE;
        end
    end

    assign o_result.valid          = r_out_valid;
    assign o_result.relay_on       = r_relay_on;
    assign o_result.hours_left     = r_hours;
    assign o_result.minutes_left   = r_minutes;
    assign o_result.seconds_left   = r_seconds;
    assign o_result.fragrance_left = r_fragrance;
    assign o_result.fragrance_over = r_fragrance == '0;
    assign o_result.run_done       = r_done;

    `CRCT_ASSERT(a_done_sticky, r_st.phase == crct_pkg::PH_DONE && !(w_s1_fire && r_s1.restart) |=> r_st.phase == crct_pkg::PH_DONE, "run left done without restart")
    `CRCT_ASSERT(a_state_hold, !w_s1_fire |=> $stable(r_st), "state moved without a tick")
    `CRCT_ASSERT(a_relay_off_done, r_out_valid |-> !(o_result.relay_on && o_result.run_done), "relay on after run done")
    `CRCT_ASSERT_RST(a_reset_empty, !i_rst_n |=> !r_s1_valid && !r_out_valid, "pipeline not empty after reset")
endmodule
`default_nettype wire

// ===== tb/sv/crct_tick_checker.sv =====
// Status checker: predicts every result item of the relay countdown timer and compares it.
module crct_tick_checker
    import crct_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    crct_in_if   i_item,
    crct_cfg_if  i_cfg,
    crct_out_if  i_result,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    localparam int SecsPerMin  = 60;
    localparam int SecsPerHour = 3600;

    typedef struct packed {
        logic               relay_on;
        logic [HoursW-1:0]  hours_left;
        logic [MinSecW-1:0] minutes_left;
        logic [MinSecW-1:0] seconds_left;
        logic [FragW-1:0]   fragrance_left;
        logic               fragrance_over;
        logic               run_done;
    } t_status;

    t_cfg                regs;
    t_phase              phase;
    logic [TicksW-1:0]   ticks_left;
    logic [ElapsedW-1:0] elapsed;
    logic [HoursW-1:0]   hours;
    logic [MinSecW-1:0]  minutes;
    logic [MinSecW-1:0]  seconds;
    logic [FragW-1:0]    fragrance;

    t_status expected_status_q[$];
    int      mismatches = 0;
    int      waiting    = 0;

    assign o_fail_count = mismatches;
    assign o_pending    = waiting;

    function automatic void restart_run();
        phase      = PH_FIRST_ON;
        ticks_left = TicksW'(int'(regs.first_on_minutes) * SecsPerMin);
        elapsed    = '0;
        hours      = regs.total_hours;
        minutes    = '0;
        seconds    = '0;
        fragrance  = regs.start_fragrance;
    endfunction

    // Limit is looked at only when a phase runs out.
    function automatic void settle_phase();
        for (int n = 0; n < SettleSteps; n++) begin
            if (phase == PH_DONE || ticks_left != 0) break;
            if (int'(elapsed) >= int'(regs.total_hours) * SecsPerHour) begin
                phase = PH_DONE;
            end else if (phase == PH_OFF) begin
                phase      = PH_ON;
                ticks_left = TicksW'(int'(regs.on_minutes) * SecsPerMin);
            end else begin
                phase      = PH_OFF;
                ticks_left = TicksW'(int'(regs.off_minutes) * SecsPerMin);
            end
        end
        // on and off both empty: the cycle can never move on
        if (phase != PH_DONE && ticks_left == 0) phase = PH_DONE;
    endfunction

    function automatic void count_down();
        if (seconds == 0) begin
            // hold at 0:00:00
            if (minutes == 0 && hours == 0) return;
            if (minutes == 0) begin
                minutes = LAST_MIN;
                hours   = hours - 1'b1;
                if (fragrance != 0) fragrance = fragrance - 1'b1;
            end else begin
                minutes = minutes - 1'b1;
            end
            seconds = LAST_MIN;
        end else begin
            seconds = seconds - 1'b1;
        end
    endfunction

    function automatic t_status advance_timer(input t_tick tick);
        t_status s;
        if (tick.restart) restart_run();
        settle_phase();
        s.relay_on = 1'b0;
        if (phase != PH_DONE) begin
            s.relay_on = (phase != PH_OFF);
            if (tick.refill_pressed) fragrance = regs.refill_amount;
            count_down();
            if (elapsed != ELAPSED_MAX) elapsed = elapsed + 1'b1;
            ticks_left = ticks_left - 1'b1;
        end
        s.hours_left     = hours;
        s.minutes_left   = minutes;
        s.seconds_left   = seconds;
        s.fragrance_left = fragrance;
        s.fragrance_over = (fragrance == 0);
        s.run_done       = (phase == PH_DONE);
        return s;
    endfunction

    task automatic check_field(input string field, input int want, input int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", field, want, got);
            mismatches++;
        end
    endtask

    always @(posedge i_clk) begin
        t_status want;
        t_status got;
        t_tick   tick;
        if (!i_rst_n) begin
            regs = '0;
            restart_run();
            expected_status_q.delete();
        end else begin
            // compare before pushing so a stray result never meets a fresh expectation
            if (i_result.valid && i_result.ready) begin
                got.relay_on       = i_result.relay_on;
                got.hours_left     = i_result.hours_left;
                got.minutes_left   = i_result.minutes_left;
                got.seconds_left   = i_result.seconds_left;
                got.fragrance_left = i_result.fragrance_left;
                got.fragrance_over = i_result.fragrance_over;
                got.run_done       = i_result.run_done;
                if (expected_status_q.size() == 0) begin
                    $error("status item arrived with no tick waiting");
                    mismatches++;
                end else begin
                    want = expected_status_q.pop_front();
                    check_field("relay_on", int'(want.relay_on), int'(got.relay_on));
                    check_field("hours_left", int'(want.hours_left), int'(got.hours_left));
                    check_field("minutes_left", int'(want.minutes_left),
                                int'(got.minutes_left));
                    check_field("seconds_left", int'(want.seconds_left),
                                int'(got.seconds_left));
                    check_field("fragrance_left", int'(want.fragrance_left),
                                int'(got.fragrance_left));
                    check_field("fragrance_over", int'(want.fragrance_over),
                                int'(got.fragrance_over));
                    check_field("run_done", int'(want.run_done), int'(got.run_done));
                end
            end
            if (i_cfg.valid && i_cfg.ready) begin
                case (t_cfg_idx'(i_cfg.index))
                    CFG_FIRST_ON_MINUTES: regs.first_on_minutes = i_cfg.data;
                    CFG_ON_MINUTES:       regs.on_minutes       = i_cfg.data;
                    CFG_OFF_MINUTES:      regs.off_minutes      = i_cfg.data;
                    CFG_TOTAL_HOURS:      regs.total_hours      = i_cfg.data;
                    CFG_REFILL_AMOUNT:    regs.refill_amount    = i_cfg.data;
                    CFG_START_FRAGRANCE:  regs.start_fragrance  = i_cfg.data;
                    default: ;
                endcase
            end
            if (i_item.valid && i_item.ready) begin
                tick.restart        = i_item.restart;
                tick.refill_pressed = i_item.refill_pressed;
                expected_status_q.push_back(advance_timer(tick));
            end
        end
        waiting = expected_status_q.size();
    end

endmodule

// ===== tb/sv/tb_cyclic_relay_countdown_timer_unit.sv =====
// Testbench top: clock, reset, tick and register stimulus, idling and the verdict.
module tb_cyclic_relay_countdown_timer_unit
    import crct_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int ClkPeriod    = 10;
    localparam int CycleLimit   = 1_000_000;
    localparam int HoldCycles   = 300;
    localparam int RandomTicks  = 450;
    localparam int LongRunTicks = 30;

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;

    crct_in_if  tick_ch ();
    crct_out_if status_ch ();
    crct_cfg_if reg_ch ();

    int fail_count;
    int pending;
    bit tx_calm     = 1'b0;
    bit rx_calm     = 1'b0;
    bit rx_hold_req = 1'b0;

    always #(ClkPeriod / 2) i_clk = ~i_clk;

    cyclic_relay_countdown_timer_unit i_dut (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_item   (tick_ch),
        .i_cfg    (reg_ch),
        .o_result (status_ch)
    );

    crct_tick_checker u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_item       (tick_ch),
        .i_cfg        (reg_ch),
        .i_result     (status_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial begin
        int cycles;
        cycles = 0;
        while (cycles < CycleLimit) begin
            @(posedge i_clk);
            cycles++;
        end
        $display("[cyclic_relay_countdown_timer_unit] ERROR");
        $finish;
    end

    // Result side: random stall before each item, or one long hold on request.
    initial begin
        int gap;
        int held;
        status_ch.ready <= 1'b0;
        wait (i_rst_n);
        @(negedge i_clk);
        forever begin
            if (rx_hold_req) begin
                rx_hold_req = 1'b0;
                status_ch.ready <= 1'b0;
                for (held = 0; held < HoldCycles; held++) @(negedge i_clk);
            end else begin
                gap = rx_calm ? 0 : $urandom_range(0, 8);
                if (gap > 0) begin
                    status_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                end
            end
            status_ch.ready <= 1'b1;
            do @(posedge i_clk); while (!status_ch.valid);
            @(negedge i_clk);
        end
    end

    // Leaves valid high on return; the next call or drain decides whether it drops.
    task automatic send_tick(input bit restart, input bit refill);
        int gap;
        gap = tx_calm ? 0 : $urandom_range(0, 8);
        if (gap > 0) begin
            tick_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        tick_ch.valid          <= 1'b1;
        tick_ch.restart        <= restart;
        tick_ch.refill_pressed <= refill;
        do @(posedge i_clk); while (!tick_ch.ready);
        @(negedge i_clk);
    endtask

    task automatic send_random_ticks(input int count, input bit allow_restart);
        for (int k = 0; k < count; k++) begin
            send_tick(allow_restart && $urandom_range(0, 63) == 0, $urandom_range(0, 3) == 0);
        end
    endtask

    task automatic drain();
        tick_ch.valid <= 1'b0;
        while (pending != 0) @(negedge i_clk);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(input t_cfg_idx idx, input logic [CfgW-1:0] value);
        reg_ch.valid <= 1'b1;
        reg_ch.index <= idx;
        reg_ch.data  <= value;
        do @(posedge i_clk); while (!reg_ch.ready);
        @(negedge i_clk);
        reg_ch.valid <= 1'b0;
        @(negedge i_clk);
    endtask

    task automatic write_all(input logic [CfgW-1:0] first_on, input logic [CfgW-1:0] on_len,
                             input logic [CfgW-1:0] off_len, input logic [CfgW-1:0] total,
                             input logic [CfgW-1:0] refill, input logic [CfgW-1:0] start_frag);
        write_reg(CFG_FIRST_ON_MINUTES, first_on);
        write_reg(CFG_ON_MINUTES, on_len);
        write_reg(CFG_OFF_MINUTES, off_len);
        write_reg(CFG_TOTAL_HOURS, total);
        write_reg(CFG_REFILL_AMOUNT, refill);
        write_reg(CFG_START_FRAGRANCE, start_frag);
    endtask

    initial begin
        int   random_sent;
        int   run_idx;
        int   n;
        t_cfg cfg;
        tick_ch.valid          <= 1'b0;
        tick_ch.restart        <= 1'b0;
        tick_ch.refill_pressed <= 1'b0;
        reg_ch.valid           <= 1'b0;
        reg_ch.index           <= CFG_FIRST_ON_MINUTES;
        reg_ch.data            <= '0;
        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        // reset registers: the run ends at once and refill is ignored
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b1, 1'b1);
        drain();
        // on and off both empty with hours still to go
        write_all(8'd0, 8'd0, 8'd0, 8'd255, 8'd255, 8'd255);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        drain();
        // longest phases; hour rollover empties the fragrance, refill to zero
        write_all(8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd1);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b1, 1'b1);
        drain();
        // empty first and off phases fall through to on within one tick
        write_all(8'd0, 8'd1, 8'd0, 8'd1, 8'd200, 8'd7);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b1);
        send_tick(1'b0, 1'b0);
        drain();
        // limit already met at the first boundary
        write_all(8'd0, 8'd1, 8'd1, 8'd0, 8'd3, 8'd3);
        send_tick(1'b1, 1'b0);
        send_tick(1'b0, 1'b0);
        drain();
        // countdown held at 0:00:00 while the relay is on
        write_all(8'd1, 8'd2, 8'd2, 8'd0, 8'd9, 8'd0);
        send_tick(1'b1, 1'b1);
        send_tick(1'b0, 1'b0);
        send_tick(1'b0, 1'b1);
        drain();

        random_sent = 0;
        run_idx     = 0;
        while (random_sent < RandomTicks) begin
            cfg.first_on_minutes = ($urandom_range(0, 15) == 0) ? 8'd255 : 8'($urandom_range(0, 3));
            cfg.on_minutes       = 8'($urandom_range(0, 2));
            cfg.off_minutes      = 8'($urandom_range(0, 2));
            cfg.total_hours      = $urandom_range(0, 1) ? 8'd0 : 8'($urandom_range(1, 255));
            cfg.refill_amount    = 8'($urandom);
            cfg.start_fragrance  = ($urandom_range(0, 3) == 0) ? 8'd1 : 8'($urandom);
            if (cfg.total_hours == 0)
                n = int'(cfg.first_on_minutes) * 60 + $urandom_range(5, 40);
            else
                n = $urandom_range(30, 150);
            if (n > 200) n = 200;
            if (n > RandomTicks - random_sent) n = RandomTicks - random_sent;
            tx_calm = ($urandom_range(0, 3) == 0);
            rx_calm = ($urandom_range(0, 3) == 0);
            write_all(cfg.first_on_minutes, cfg.on_minutes, cfg.off_minutes,
                      cfg.total_hours, cfg.refill_amount, cfg.start_fragrance);
            if (run_idx == 1) begin
                // keep offering while the result side holds off
                n           = 200;
                tx_calm     = 1'b1;
                rx_calm     = 1'b0;
                rx_hold_req = 1'b1;
            end
            send_tick(1'b1, 1'($urandom_range(0, 1)));
            if (run_idx == 2) begin
                send_random_ticks(n / 2, 1'b1);
                drain();
                send_random_ticks(n - n / 2 - 1, 1'b1);
            end else begin
                send_random_ticks(n - 1, 1'b1);
            end
            drain();
            random_sent += n;
            run_idx++;
        end

        // one last run with an hour to count down, no restart along the way
        write_all(8'($urandom_range(0, 2)), 8'($urandom_range(1, 2)), 8'($urandom_range(0, 2)),
                  8'd1, 8'($urandom), 8'($urandom));
        tx_calm = 1'b1;
        rx_calm = ($urandom_range(0, 1) == 0);
        send_tick(1'b1, 1'b0);
        send_random_ticks(LongRunTicks, 1'b0);
        drain();

        if (pending != 0) $error("%0d status items never arrived", pending);
        if (fail_count == 0 && pending == 0) begin
            $display("[cyclic_relay_countdown_timer_unit] OK");
        end else begin
            $display("[cyclic_relay_countdown_timer_unit] ERROR");
        end
        $finish;
    end

endmodule
